### src/ptsd_pkg.sv
`default_nettype none

package ptsd_pkg;

  // Number format and word sizes
  localparam int FRAC_BITS = 12;
  localparam int WORD_W    = 32;
  localparam int QUOT_W    = 64;

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = QUOT_W / DIV_BITS;
  // Front register, step stages, sign and zero fixup register
  localparam int DIV_LAT   = DIV_STEPS + 2;

  localparam logic [63:0] HALF_LSB    = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] WEIGHT_ONE  = 64'(1) << 32;
  localparam logic [63:0] WEIGHT_HALF = 64'h0000_0000_8000_0000;

  // Source of an output weight
  typedef logic [2:0] wsel_t;
  localparam wsel_t WSEL_ZERO = 3'd0;
  localparam wsel_t WSEL_ONE  = 3'd1;
  localparam wsel_t WSEL_Q0   = 3'd2;  // first quotient
  localparam wsel_t WSEL_NQ0  = 3'd3;  // negated first quotient
  localparam wsel_t WSEL_OMQ0 = 3'd4;  // one minus first quotient
  localparam wsel_t WSEL_Q1   = 3'd5;  // second quotient

  // How the squared distance is formed
  typedef logic [2:0] sqmode_t;
  localparam sqmode_t SQ_DIRECT = 3'd0;  // value known before division
  localparam sqmode_t SQ_QUAD   = 3'd1;  // full quadratic form in s and t
  localparam sqmode_t SQ_LIN_S  = 3'd2;  // lin * s + c
  localparam sqmode_t SQ_LIN_T  = 3'd3;  // lin * t + c
  localparam sqmode_t SQ_LIN_FT = 3'd4;  // lin * ft + c

  // Values that ride alongside the divider
  typedef struct packed {
    wsel_t              s_sel;
    wsel_t              t_sel;
    sqmode_t            mode;
    logic signed [31:0] direct;
    logic signed [31:0] lin;
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a11;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] c;
    logic signed [31:0] ft;
  } side_t;

  // Round a 64-bit sum at the fraction point and keep 32 bits
  function automatic logic signed [31:0] rnd(input logic [63:0] sum);
    logic [63:0] tmp;
    tmp = sum + HALF_LSB;
    return tmp[FRAC_BITS +: WORD_W];
  endfunction

  // Finish a weight multiply from its low-word and high-word partial products
  function automatic logic signed [31:0] wmul_fin(input logic [63:0] lo,
                                                 input logic [31:0] hi);
    logic [63:0] tmp;
    tmp = lo + WEIGHT_HALF;
    return tmp[63:32] + hi;
  endfunction

endpackage

`default_nettype wire

### src/ptsd_div.sv
`default_nettype none

module ptsd_div
  import ptsd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] numer,
  input  logic signed [31:0] denom,
  output logic        [63:0] quot
);

  logic [31:0] nbits [DIV_STEPS+1];
  logic [31:0] rem   [DIV_STEPS+1];
  logic [31:0] dmag  [DIV_STEPS+1];
  logic [63:0] qacc  [DIV_STEPS+1];
  logic        negf  [DIV_STEPS+1];
  logic        zerof [DIV_STEPS+1];

  // Take magnitudes and remember the sign and the zero divisor
  always_ff @(posedge clk) begin
    if (en) begin
      nbits[0] <= numer[31] ? 32'(-numer) : 32'(numer);
      dmag[0]  <= denom[31] ? 32'(-denom) : 32'(denom);
      rem[0]   <= '0;
      qacc[0]  <= '0;
      negf[0]  <= numer[31] ^ denom[31];
      zerof[0] <= (denom == 32'sd0);
    end
  end

  // Restoring division, two quotient bits per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] r_n;
    logic [31:0] n_n;
    logic [63:0] q_n;

    always_comb begin
      logic [32:0] r33;
      r_n = rem[k];
      n_n = nbits[k];
      q_n = qacc[k];
      for (int b = 0; b < DIV_BITS; b++) begin
        r33 = {r_n, n_n[31]};
        if (r33 >= {1'b0, dmag[k]}) begin
          r_n = 32'(r33 - {1'b0, dmag[k]});
          q_n = {q_n[62:0], 1'b1};
        end else begin
          r_n = r33[31:0];
          q_n = {q_n[62:0], 1'b0};
        end
        n_n = {n_n[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= r_n;
        nbits[k+1] <= n_n;
        qacc[k+1]  <= q_n;
        dmag[k+1]  <= dmag[k];
        negf[k+1]  <= negf[k];
        zerof[k+1] <= zerof[k];
      end
    end
  end

  // Apply the sign; a zero divisor saturates to all ones
  always_ff @(posedge clk) begin
    if (en) begin
      if (zerof[DIV_STEPS]) begin
        quot <= '1;
      end else if (negf[DIV_STEPS]) begin
        quot <= -qacc[DIV_STEPS];
      end else begin
        quot <= qacc[DIV_STEPS];
      end
    end
  end

endmodule

`default_nettype wire

### src/point_triangle_sq_distance_top.sv
`default_nettype none

// Squared distance from a query point to a triangle, signed 20.12 fixed point.
// One query enters per clock cycle while the skid register is empty. The pipeline
// length is set mostly by the two 64-bit quotient dividers, which resolve two
// quotient bits per stage. The remaining stages form the differences, the six
// dot products, the determinant and fS/fT, the region decision, and the two
// weight-multiply layers of the quadratic form. An output register plus a skid
// register decouple the stream sides, so a new query is taken while a finished
// result waits in the output register. Results: sq_distance (20.12, absolute),
// coord_s and coord_t (32.32, low 33 bits).

module point_triangle_sq_distance_top
  import ptsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
  // vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z (32 bits each)
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sq_distance [31:0], coord_s [64:32], coord_t [97:65], zero fill [103:98]
  output logic [103:0] m_tdata
);

  localparam int A00 = 0;
  localparam int A01 = 1;
  localparam int A11 = 2;
  localparam int B0  = 3;
  localparam int B1  = 4;
  localparam int CC  = 5;

  logic adv;
  logic sk_valid;
  logic [103:0] sk_data;

  assign adv      = !sk_valid;
  assign s_tready = adv;

  // ---------------------------------------------------------------- stage 1
  logic signed [31:0] in_w [12];
  logic               v1;
  logic signed [31:0] st1_d  [3];
  logic signed [31:0] st1_e0 [3];
  logic signed [31:0] st1_e1 [3];

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      in_w[i] = s_tdata[32*i +: 32];
    end
  end

  // Form D = V0 - P, E0 = V1 - V0, E1 = V2 - V0
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        st1_d[i]  <= in_w[3+i] - in_w[i];
        st1_e0[i] <= in_w[6+i] - in_w[3+i];
        st1_e1[i] <= in_w[9+i] - in_w[3+i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic               v2;
  logic signed [63:0] st2_p [6][3];

  // Multiply component pairs for the six dot products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        st2_p[A00][i] <= st1_e0[i] * st1_e0[i];
        st2_p[A01][i] <= st1_e0[i] * st1_e1[i];
        st2_p[A11][i] <= st1_e1[i] * st1_e1[i];
        st2_p[B0][i]  <= st1_d[i] * st1_e0[i];
        st2_p[B1][i]  <= st1_d[i] * st1_e1[i];
        st2_p[CC][i]  <= st1_d[i] * st1_d[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic               v3;
  logic [63:0]        dsum [6];
  logic signed [31:0] st3_dot [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dsum[k] = st2_p[k][0] + st2_p[k][1] + st2_p[k][2];
    end
  end

  // Sum and round the dot products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        st3_dot[k] <= rnd(dsum[k]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic               v4;
  logic signed [63:0] st4_x [6];
  logic signed [31:0] st4_dot [6];

  // Multiply for the determinant and the unnormalized fS and fT
  always_ff @(posedge clk) begin
    if (adv) begin
      st4_x[0] <= st3_dot[A00] * st3_dot[A11];
      st4_x[1] <= st3_dot[A01] * st3_dot[A01];
      st4_x[2] <= st3_dot[A01] * st3_dot[B1];
      st4_x[3] <= st3_dot[A11] * st3_dot[B0];
      st4_x[4] <= st3_dot[A01] * st3_dot[B0];
      st4_x[5] <= st3_dot[A00] * st3_dot[B1];
      st4_dot  <= st3_dot;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic               v5;
  logic signed [31:0] st5_det;
  logic signed [31:0] st5_fs;
  logic signed [31:0] st5_ft;
  logic signed [31:0] st5_dot [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      st5_det <= rnd(64'(st4_x[0] - st4_x[1]));
      st5_fs  <= rnd(64'(st4_x[2] - st4_x[3]));
      st5_ft  <= rnd(64'(st4_x[4] - st4_x[5]));
      st5_dot <= st4_dot;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic               v6;
  logic signed [31:0] st6_det;
  logic signed [31:0] st6_sft;
  logic signed [31:0] st6_denom;
  logic               st6_r2;
  logic signed [31:0] st6_t0;
  logic signed [31:0] st6_t1;
  logic signed [31:0] st6_numr;
  logic signed [31:0] st6_numo;
  logic signed [31:0] st6_ee00;
  logic signed [31:0] st6_ee11;
  logic signed [31:0] st6_nb0;
  logic signed [31:0] st6_nb1;
  logic signed [31:0] st6_fs;
  logic signed [31:0] st6_ft;
  logic signed [31:0] st6_dot [6];

  // Form the sums that the region decision compares
  always_ff @(posedge clk) begin
    if (adv) begin
      st6_det   <= st5_det[31] ? -st5_det : st5_det;
      st6_sft   <= st5_fs + st5_ft;
      st6_denom <= st5_dot[A00] - (st5_dot[A01] + st5_dot[A01]) + st5_dot[A11];
      st6_r2    <= st5_fs[31];
      if (st5_fs[31]) begin
        st6_t0   <= st5_dot[A01] + st5_dot[B0];
        st6_t1   <= st5_dot[A11] + st5_dot[B1];
        st6_numr <= (st5_dot[A11] + st5_dot[B1]) - (st5_dot[A01] + st5_dot[B0]);
      end else begin
        st6_t0   <= st5_dot[A01] + st5_dot[B1];
        st6_t1   <= st5_dot[A00] + st5_dot[B0];
        st6_numr <= (st5_dot[A00] + st5_dot[B0]) - (st5_dot[A01] + st5_dot[B1]);
      end
      st6_numo <= st5_dot[A11] + st5_dot[B1] - st5_dot[A01] - st5_dot[B0];
      st6_ee00 <= st5_dot[A00] + (st5_dot[B0] + st5_dot[B0]) + st5_dot[CC];
      st6_ee11 <= st5_dot[A11] + (st5_dot[B1] + st5_dot[B1]) + st5_dot[CC];
      st6_nb0  <= -st5_dot[B0];
      st6_nb1  <= -st5_dot[B1];
      st6_fs   <= st5_fs;
      st6_ft   <= st5_ft;
      st6_dot  <= st5_dot;
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic               v7;
  logic signed [31:0] st7_n0;
  logic signed [31:0] st7_d0;
  logic signed [31:0] st7_n1;
  logic signed [31:0] st7_d1;
  side_t              st7_side;

  logic signed [31:0] cls_n0;
  logic signed [31:0] cls_d0;
  logic signed [31:0] cls_n1;
  logic signed [31:0] cls_d1;
  side_t              cls_side;

  // Classify the point into its region of the parameter plane
  always_comb begin
    wsel_t              cs_sel;
    sqmode_t            cs_mode;
    logic signed [31:0] cs_direct;
    wsel_t              ct_sel;
    sqmode_t            ct_mode;
    logic signed [31:0] ct_direct;
    wsel_t              far_sel;
    wsel_t              near_sel;
    logic signed [31:0] bn;
    logic signed [31:0] an;

    // Clamp along edge zero from vertex zero
    if (!st6_dot[B0][31]) begin
      cs_sel = WSEL_ZERO; cs_mode = SQ_DIRECT; cs_direct = st6_dot[CC];
    end else if (st6_nb0 >= st6_dot[A00]) begin
      cs_sel = WSEL_ONE;  cs_mode = SQ_DIRECT; cs_direct = st6_ee00;
    end else begin
      cs_sel = WSEL_NQ0;  cs_mode = SQ_LIN_S;  cs_direct = st6_dot[CC];
    end
    // Clamp along edge one from vertex zero
    if (!st6_dot[B1][31]) begin
      ct_sel = WSEL_ZERO; ct_mode = SQ_DIRECT; ct_direct = st6_dot[CC];
    end else if (st6_nb1 >= st6_dot[A11]) begin
      ct_sel = WSEL_ONE;  ct_mode = SQ_DIRECT; ct_direct = st6_ee11;
    end else begin
      ct_sel = WSEL_NQ0;  ct_mode = SQ_LIN_T;  ct_direct = st6_dot[CC];
    end

    bn       = st6_r2 ? st6_dot[B1] : st6_dot[B0];
    an       = st6_r2 ? st6_dot[A11] : st6_dot[A00];
    far_sel  = WSEL_ZERO;
    near_sel = WSEL_ZERO;

    cls_n0          = '0;
    cls_d0          = '0;
    cls_n1          = '0;
    cls_d1          = '0;
    cls_side.s_sel  = WSEL_ZERO;
    cls_side.t_sel  = WSEL_ZERO;
    cls_side.mode   = SQ_DIRECT;
    cls_side.direct = st6_dot[CC];
    cls_side.lin    = '0;
    cls_side.a00    = st6_dot[A00];
    cls_side.a01    = st6_dot[A01];
    cls_side.a11    = st6_dot[A11];
    cls_side.b0     = st6_dot[B0];
    cls_side.b1     = st6_dot[B1];
    cls_side.c      = st6_dot[CC];
    cls_side.ft     = st6_ft;

    if (st6_sft <= st6_det) begin
      if (st6_fs[31] && st6_ft[31] && st6_dot[B0][31]) begin
        cls_side.s_sel = cs_sel; cls_side.mode = cs_mode; cls_side.direct = cs_direct;
        cls_n0 = st6_dot[B0]; cls_d0 = st6_dot[A00]; cls_side.lin = st6_dot[B0];
      end else if (st6_fs[31]) begin
        cls_side.t_sel = ct_sel; cls_side.mode = ct_mode; cls_side.direct = ct_direct;
        cls_n0 = st6_dot[B1]; cls_d0 = st6_dot[A11]; cls_side.lin = st6_dot[B1];
        // With fT not negative the edge interior uses the unclamped fT
        if (!st6_ft[31] && ct_mode == SQ_LIN_T) begin
          cls_side.mode = SQ_LIN_FT;
        end
      end else if (st6_ft[31]) begin
        cls_side.s_sel = cs_sel; cls_side.mode = cs_mode; cls_side.direct = cs_direct;
        cls_n0 = st6_dot[B0]; cls_d0 = st6_dot[A00]; cls_side.lin = st6_dot[B0];
      end else begin
        cls_side.s_sel = WSEL_Q0;
        cls_side.t_sel = WSEL_Q1;
        cls_side.mode  = SQ_QUAD;
        cls_n0 = st6_fs; cls_d0 = st6_det;
        cls_n1 = st6_ft; cls_d1 = st6_det;
      end
    end else if (st6_fs[31] || st6_ft[31]) begin
      if (st6_t1 > st6_t0) begin
        cls_n0 = st6_numr; cls_d0 = st6_denom;
        if (st6_numr >= st6_denom) begin
          far_sel = WSEL_ONE; near_sel = WSEL_ZERO;
          cls_side.direct = st6_r2 ? st6_ee00 : st6_ee11;
        end else begin
          far_sel = WSEL_Q0; near_sel = WSEL_OMQ0;
          cls_side.mode = SQ_QUAD;
        end
      end else begin
        far_sel = WSEL_ZERO;
        if (st6_t1 <= 32'sd0) begin
          near_sel = WSEL_ONE;
          cls_side.direct = st6_r2 ? st6_ee11 : st6_ee00;
        end else if (!bn[31]) begin
          near_sel = WSEL_ZERO;
        end else begin
          near_sel = WSEL_NQ0;
          cls_n0 = bn; cls_d0 = an; cls_side.lin = bn;
          cls_side.mode = st6_r2 ? SQ_LIN_T : SQ_LIN_S;
        end
      end
      cls_side.s_sel = st6_r2 ? far_sel : near_sel;
      cls_side.t_sel = st6_r2 ? near_sel : far_sel;
    end else begin
      cls_n0 = st6_numo; cls_d0 = st6_denom;
      if (st6_numo <= 32'sd0) begin
        cls_side.t_sel = WSEL_ONE;
        cls_side.direct = st6_ee11;
      end else if (st6_numo >= st6_denom) begin
        cls_side.s_sel = WSEL_ONE;
        cls_side.direct = st6_ee00;
      end else begin
        cls_side.s_sel = WSEL_Q0;
        cls_side.t_sel = WSEL_OMQ0;
        cls_side.mode  = SQ_QUAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st7_n0   <= cls_n0;
      st7_d0   <= cls_d0;
      st7_n1   <= cls_n1;
      st7_d1   <= cls_d1;
      st7_side <= cls_side;
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [63:0] quot0;
  logic [63:0] quot1;
  side_t       side_q [DIV_LAT];
  logic        vq     [DIV_LAT];

  ptsd_div u_div0 (
    .clk   (clk),
    .en    (adv),
    .numer (st7_n0),
    .denom (st7_d0),
    .quot  (quot0)
  );

  ptsd_div u_div1 (
    .clk   (clk),
    .en    (adv),
    .numer (st7_n1),
    .denom (st7_d1),
    .quot  (quot1)
  );

  // Carry the region decision alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= st7_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 8
  logic        v8;
  logic [63:0] st8_s;
  logic [63:0] st8_t;
  side_t       st8_side;

  function automatic logic [63:0] wpick(input wsel_t sel, input logic [63:0] q0,
                                        input logic [63:0] q1);
    case (sel)
      WSEL_ZERO: return '0;
      WSEL_ONE:  return WEIGHT_ONE;
      WSEL_Q0:   return q0;
      WSEL_NQ0:  return -q0;
      WSEL_OMQ0: return WEIGHT_ONE - q0;
      WSEL_Q1:   return q1;
      default:   return '0;
    endcase
  endfunction

  // Pick the output weights
  always_ff @(posedge clk) begin
    if (adv) begin
      st8_s    <= wpick(side_q[DIV_LAT-1].s_sel, quot0, quot1);
      st8_t    <= wpick(side_q[DIV_LAT-1].t_sel, quot0, quot1);
      st8_side <= side_q[DIV_LAT-1];
    end
  end

  // ---------------------------------------------------------------- stage 9
  logic               v9;
  logic signed [63:0] st9_lo [4];
  logic [31:0]        st9_hi [4];
  logic [63:0]        st9_s;
  logic [63:0]        st9_t;
  side_t              st9_side;
  logic signed [32:0] s_lo_sx;
  logic signed [32:0] t_lo_sx;

  assign s_lo_sx = {1'b0, st8_s[31:0]};
  assign t_lo_sx = {1'b0, st8_t[31:0]};

  // Partial products of the inner weight multiplies
  always_ff @(posedge clk) begin
    if (adv) begin
      st9_lo[0] <= s_lo_sx * st8_side.a00;
      st9_hi[0] <= st8_s[63:32] * st8_side.a00;
      st9_lo[1] <= t_lo_sx * st8_side.a01;
      st9_hi[1] <= st8_t[63:32] * st8_side.a01;
      st9_lo[2] <= s_lo_sx * st8_side.a01;
      st9_hi[2] <= st8_s[63:32] * st8_side.a01;
      st9_lo[3] <= t_lo_sx * st8_side.a11;
      st9_hi[3] <= st8_t[63:32] * st8_side.a11;
      st9_s     <= st8_s;
      st9_t     <= st8_t;
      st9_side  <= st8_side;
    end
  end

  // ---------------------------------------------------------------- stage 10
  logic               v10;
  logic signed [31:0] st10_u;
  logic [63:0]        st10_wu;
  logic signed [31:0] st10_v;
  logic [63:0]        st10_wv;
  logic signed [31:0] st10_base;
  logic [63:0]        st10_s;
  logic [63:0]        st10_t;
  logic signed [31:0] quad_u;
  logic signed [31:0] quad_v;

  assign quad_u = wmul_fin(st9_lo[0], st9_hi[0]) + wmul_fin(st9_lo[1], st9_hi[1])
                + (st9_side.b0 + st9_side.b0);
  assign quad_v = wmul_fin(st9_lo[2], st9_hi[2]) + wmul_fin(st9_lo[3], st9_hi[3])
                + (st9_side.b1 + st9_side.b1);

  // Select the terms of the final weighted sum
  always_ff @(posedge clk) begin
    if (adv) begin
      st10_s    <= st9_s;
      st10_t    <= st9_t;
      st10_base <= st9_side.c;
      st10_v    <= '0;
      st10_wv   <= '0;
      case (st9_side.mode)
        SQ_QUAD: begin
          st10_u  <= quad_u;
          st10_wu <= st9_s;
          st10_v  <= quad_v;
          st10_wv <= st9_t;
        end
        SQ_LIN_S: begin
          st10_u  <= st9_side.lin;
          st10_wu <= st9_s;
        end
        SQ_LIN_T: begin
          st10_u  <= st9_side.lin;
          st10_wu <= st9_t;
        end
        SQ_LIN_FT: begin
          st10_u  <= st9_side.lin;
          st10_wu <= {{32{st9_side.ft[31]}}, st9_side.ft};
        end
        default: begin
          st10_u    <= '0;
          st10_wu   <= '0;
          st10_base <= st9_side.direct;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 11
  logic               v11;
  logic signed [63:0] st11_lo [2];
  logic [31:0]        st11_hi [2];
  logic signed [31:0] st11_base;
  logic [63:0]        st11_s;
  logic [63:0]        st11_t;
  logic signed [32:0] wu_lo_sx;
  logic signed [32:0] wv_lo_sx;

  assign wu_lo_sx = {1'b0, st10_wu[31:0]};
  assign wv_lo_sx = {1'b0, st10_wv[31:0]};

  // Partial products of the outer weight multiplies
  always_ff @(posedge clk) begin
    if (adv) begin
      st11_lo[0] <= wu_lo_sx * st10_u;
      st11_hi[0] <= st10_wu[63:32] * st10_u;
      st11_lo[1] <= wv_lo_sx * st10_v;
      st11_hi[1] <= st10_wv[63:32] * st10_v;
      st11_base  <= st10_base;
      st11_s     <= st10_s;
      st11_t     <= st10_t;
    end
  end

  // ---------------------------------------------------------------- stage 12
  logic               v12;
  logic signed [31:0] st12_mu;
  logic signed [31:0] st12_mv;
  logic signed [31:0] st12_base;
  logic [63:0]        st12_s;
  logic [63:0]        st12_t;

  always_ff @(posedge clk) begin
    if (adv) begin
      st12_mu   <= wmul_fin(st11_lo[0], st11_hi[0]);
      st12_mv   <= wmul_fin(st11_lo[1], st11_hi[1]);
      st12_base <= st11_base;
      st12_s    <= st11_s;
      st12_t    <= st11_t;
    end
  end

  // Final sum and absolute value
  logic signed [31:0] sq_sum;
  logic signed [31:0] sq_abs;
  logic [103:0]       res_data;

  assign sq_sum   = st12_mu + st12_mv + st12_base;
  assign sq_abs   = sq_sum[31] ? -sq_sum : sq_sum;
  assign res_data = {6'b0, st12_t[32:0], st12_s[32:0], sq_abs};

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vq[i] <= 1'b0;
      end
    end else if (adv) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      v7    <= v6;
      vq[0] <= v7;
      for (int i = 1; i < DIV_LAT; i++) begin
        vq[i] <= vq[i-1];
      end
      v8    <= vq[DIV_LAT-1];
      v9    <= v8;
      v10   <= v9;
      v11   <= v10;
      v12   <= v11;
    end
  end

  // ---------------------------------------------------------------- output and skid
  // Hold a transaction in the skid register when the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (sk_valid) begin
      if (m_tready) begin
        m_tdata  <= sk_data;
        sk_valid <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= v12;
      m_tdata  <= res_data;
    end else if (v12) begin
      sk_valid <= 1'b1;
      sk_data  <= res_data;
    end
  end

endmodule

`default_nettype wire
